// ===== rtl/vrt_pkg.sv =====
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the voxel ray traversal block
// Register indexes, field widths and the per-ray record that the setup
// front end hands over to the cell walker.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int COORD_W = 24;   // world coordinate, 8 fraction bits
    localparam int CELL_W  = 16;   // voxel index on the result port
    localparam int IDX_W   = 18;   // internal voxel index, room for min + length
    localparam int TD_W    = 48;   // travel values, 24 fraction bits
    localparam int TD_FRAC = 24;
    localparam int CS_W    = 16;   // cell size
    localparam int DIV_W   = 40;   // dividend of the per-axis divider
    localparam int DSR_W   = 25;   // divisor of the per-axis divider
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_MIN_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_MIN_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_MIN_Z = 3'd6;

    typedef struct packed {
        logic signed [IDX_W-1:0] cell_start;
        logic signed [IDX_W-1:0] cell_end;
        logic                    dir_pos;
        logic [TD_W-1:0]         delta;
        logic [TD_W-1:0]         travel;
    } axis_rec_t;

    typedef struct packed {
        axis_rec_t x;
        axis_rec_t y;
        axis_rec_t z;
        logic      outside;
    } ray_rec_t;

endpackage

// ===== rtl/vrt_div.sv =====
// ----------------------------------------------------------------------------
// vrt_div: unsigned restoring divider
// One quotient bit per cycle. A short operation runs 25 steps on a dividend
// that is given pre-shifted to the top; a long one runs all 40 steps.
// ----------------------------------------------------------------------------
module vrt_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic                       short_op,
    input  logic [vrt_pkg::DIV_W-1:0]  dividend,
    input  logic [vrt_pkg::DSR_W-1:0]  divisor,
    output logic                       done,
    output logic [vrt_pkg::DIV_W-1:0]  quotient,
    output logic [vrt_pkg::DSR_W-1:0]  remainder
);
    import vrt_pkg::*;

    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DSR_W:0]   shifted;
    logic             fits;

    always_comb begin
        shifted   = {rem_reg, dq_reg[DIV_W-1]};
        fits      = shifted >= {1'b0, divisor};
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            dq_next  = dividend;
            rem_next = '0;
            cnt_next = short_op ? 6'd25 : 6'd40;
        end else if (cnt_reg != 6'd0) begin
            dq_next   = {dq_reg[DIV_W-2:0], fits};
            rem_next  = fits ? DSR_W'(shifted - {1'b0, divisor}) : shifted[DSR_W-1:0];
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/vrt_axis.sv =====
// ----------------------------------------------------------------------------
// vrt_axis: per-axis ray setup
// Finds the start and end cells, the step direction, the travel increment
// and the first boundary distance of one axis with up to four divisions.
// ----------------------------------------------------------------------------
module vrt_axis #(
    parameter int GRID_LEN = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [vrt_pkg::COORD_W-1:0]   start_pos,
    input  logic signed [vrt_pkg::COORD_W-1:0]   end_pos,
    input  logic signed [vrt_pkg::COORD_W-1:0]   origin,
    input  logic        [vrt_pkg::CS_W-1:0]      cell_size,
    input  logic signed [vrt_pkg::CELL_W-1:0]    index_min,
    output logic                                 done,
    output logic                                 outside,
    output vrt_pkg::axis_rec_t                   rec
);
    import vrt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_S    = 3'd1;
    localparam logic [2:0] ST_E    = 3'd2;
    localparam logic [2:0] ST_DEL  = 3'd3;
    localparam logic [2:0] ST_TD   = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]                state_reg, state_next;
    logic                      kick_reg, kick_next;
    logic signed [COORD_W:0]   rs_reg, re_reg, d_reg;
    logic [CS_W-1:0]           cs_reg;
    logic signed [IDX_W-1:0]   lo_reg;
    logic signed [COORD_W+1:0] qs_reg, qs_next, qe_reg, qe_next;
    logic [CS_W-1:0]           ms_reg, ms_next, me_reg, me_next;
    logic [TD_W-1:0]           delta_reg, delta_next, td_reg, td_next;

    logic                      div_done;
    logic [DIV_W-1:0]          quo;
    logic [DSR_W-1:0]          rem;
    logic                      short_op;
    logic [DIV_W-1:0]          dividend;
    logic [DSR_W-1:0]          divisor;

    logic signed [COORD_W:0]   cur_r;
    logic [COORD_W:0]          abs_r, abs_d;
    logic                      cur_neg, rem_nz;
    logic [COORD_W+1:0]        q_mag;
    logic signed [COORD_W+1:0] q_fl;
    logic [CS_W-1:0]           m_fl, b_val;
    logic signed [COORD_W+1:0] lo_w, hi_w, lim_w;

    assign cur_r   = (state_reg == ST_S) ? rs_reg : re_reg;
    assign cur_neg = cur_r[COORD_W];
    assign abs_r   = cur_neg ? (COORD_W+1)'(-cur_r) : cur_r;
    assign abs_d   = d_reg[COORD_W] ? (COORD_W+1)'(-d_reg) : d_reg;
    assign b_val   = d_reg[COORD_W] ? ms_reg : cs_reg - ms_reg;

    always_comb begin
        short_op = 1'b0;
        dividend = {cs_reg, {TD_FRAC{1'b0}}};
        divisor  = abs_d;
        case (state_reg)
            ST_S, ST_E: begin
                short_op = 1'b1;
                dividend = {abs_r, {(DIV_W-COORD_W-1){1'b0}}};
                divisor  = {{(DSR_W-CS_W){1'b0}}, cs_reg};
            end
            ST_TD: dividend = {b_val, {TD_FRAC{1'b0}}};
            default: dividend = {cs_reg, {TD_FRAC{1'b0}}};
        endcase
    end

    vrt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (kick_reg),
        .short_op  (short_op),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // Floor division of a signed offset from the unsigned magnitude result.
    assign rem_nz = rem[CS_W-1:0] != '0;
    assign q_mag  = {1'b0, quo[COORD_W:0]};
    assign q_fl   = cur_neg ? $signed(~q_mag + (COORD_W+2)'(!rem_nz)) : $signed(q_mag);
    assign m_fl   = (cur_neg && rem_nz) ? cs_reg - rem[CS_W-1:0] : rem[CS_W-1:0];

    always_comb begin
        state_next = state_reg;
        kick_next  = 1'b0;
        qs_next    = qs_reg;
        qe_next    = qe_reg;
        ms_next    = ms_reg;
        me_next    = me_reg;
        delta_next = delta_reg;
        td_next    = td_reg;
        case (state_reg)
            ST_IDLE, ST_DONE: begin
                if (start) begin
                    state_next = ST_S;
                    kick_next  = 1'b1;
                end
            end
            ST_S: begin
                if (div_done) begin
                    qs_next    = q_fl;
                    ms_next    = m_fl;
                    state_next = ST_E;
                    kick_next  = 1'b1;
                end
            end
            ST_E: begin
                if (div_done) begin
                    qe_next = q_fl;
                    me_next = m_fl;
                    if (d_reg == '0) begin
                        delta_next = '1;
                        td_next    = '1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DEL;
                        kick_next  = 1'b1;
                    end
                end
            end
            ST_DEL: begin
                if (div_done) begin
                    delta_next = {{(TD_W-DIV_W){1'b0}}, quo};
                    state_next = ST_TD;
                    kick_next  = 1'b1;
                end
            end
            ST_TD: begin
                if (div_done) begin
                    td_next    = {{(TD_W-DIV_W){1'b0}}, quo};
                    state_next = ST_DONE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kick_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            kick_reg  <= kick_next;
        end
        if ((state_reg == ST_IDLE || state_reg == ST_DONE) && start) begin
            rs_reg <= (COORD_W+1)'(start_pos) - (COORD_W+1)'(origin);
            re_reg <= (COORD_W+1)'(end_pos) - (COORD_W+1)'(origin);
            d_reg  <= (COORD_W+1)'(end_pos) - (COORD_W+1)'(start_pos);
            cs_reg <= (cell_size == '0) ? CS_W'(1) : cell_size;
            lo_reg <= IDX_W'(index_min);
        end
        qs_reg    <= qs_next;
        qe_reg    <= qe_next;
        ms_reg    <= ms_next;
        me_reg    <= me_next;
        delta_reg <= delta_next;
        td_reg    <= td_next;
    end

    // Clamp to the map range and test the end point against the map box.
    assign lo_w  = (COORD_W+2)'(lo_reg);
    assign hi_w  = lo_w + (COORD_W+2)'(GRID_LEN - 1);
    assign lim_w = lo_w + (COORD_W+2)'(GRID_LEN);

    always_comb begin
        rec.cell_start = IDX_W'(qs_reg);
        if (qs_reg < lo_w)      rec.cell_start = IDX_W'(lo_w);
        else if (qs_reg > hi_w) rec.cell_start = IDX_W'(hi_w);
        rec.cell_end = IDX_W'(qe_reg);
        if (qe_reg < lo_w)      rec.cell_end = IDX_W'(lo_w);
        else if (qe_reg > hi_w) rec.cell_end = IDX_W'(hi_w);
        rec.dir_pos = !d_reg[COORD_W] && (d_reg != '0);
        rec.delta   = delta_reg;
        rec.travel  = td_reg;
    end

    assign outside = (qe_reg < lo_w) || (qe_reg > lim_w) ||
                     ((qe_reg == lim_w) && (me_reg != '0));
    assign done    = (state_reg == ST_DONE);

endmodule

// ===== rtl/vrt_fifo.sv =====
// ----------------------------------------------------------------------------
// vrt_fifo: two-entry queue of ray records
// Sits between the setup front end and the cell walker.
// ----------------------------------------------------------------------------
module vrt_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  vrt_pkg::ray_rec_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output vrt_pkg::ray_rec_t pop_data
);
    import vrt_pkg::*;

    ray_rec_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) mem_reg[wp_reg] <= push_data;
    end

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign pop_data = mem_reg[rp_reg];

endmodule

// ===== rtl/vrt_walk.sv =====
// ----------------------------------------------------------------------------
// vrt_walk: cell walker
// Steps through the voxels of one ray, one cell per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module vrt_walk #(
    parameter int GRID_LEN = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               rec_empty,
    input  vrt_pkg::ray_rec_t                  rec,
    output logic                               rec_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [3*vrt_pkg::CELL_W-1:0]       m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import vrt_pkg::*;

    localparam int MAXR = 3 * (GRID_LEN - 1) + 1;
    localparam int CW   = $clog2(MAXR);

    logic                    active_reg;
    logic [CW-1:0]           n_reg;
    logic                    outside_reg;
    logic signed [IDX_W-1:0] x_reg, y_reg, z_reg, xe_reg, ye_reg, ze_reg;
    logic                    px_reg, py_reg, pz_reg;
    logic [TD_W-1:0]         tx_reg, ty_reg, tz_reg, dx_reg, dy_reg, dz_reg;
    logic                    ov_reg;
    logic [3*CELL_W-1:0]     od_reg;
    logic                    ol_reg, ou_reg;

    logic xne, yne, zne, is_last, adv, sel_x, sel_y;
    logic [TD_W:0] sx, sy, sz;

    assign xne     = x_reg != xe_reg;
    assign yne     = y_reg != ye_reg;
    assign zne     = z_reg != ze_reg;
    assign is_last = !(xne || yne || zne) || (n_reg == CW'(MAXR - 1));
    assign adv     = active_reg && (!ov_reg || m_tready);
    assign sel_x   = (tx_reg < ty_reg && tx_reg < tz_reg && xne) || (!yne && !zne);
    assign sel_y   = !sel_x && ((ty_reg < tz_reg && yne) || !zne);
    assign sx      = {1'b0, tx_reg} + {1'b0, dx_reg};
    assign sy      = {1'b0, ty_reg} + {1'b0, dy_reg};
    assign sz      = {1'b0, tz_reg} + {1'b0, dz_reg};
    assign rec_pop = !active_reg && !rec_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            if (rec_pop)              active_reg <= 1'b1;
            else if (adv && is_last)  active_reg <= 1'b0;
            if (adv)                  ov_reg <= 1'b1;
            else if (m_tready)        ov_reg <= 1'b0;
        end
        if (rec_pop) begin
            n_reg       <= '0;
            outside_reg <= rec.outside;
            x_reg  <= rec.x.cell_start;  xe_reg <= rec.x.cell_end;
            y_reg  <= rec.y.cell_start;  ye_reg <= rec.y.cell_end;
            z_reg  <= rec.z.cell_start;  ze_reg <= rec.z.cell_end;
            px_reg <= rec.x.dir_pos;  tx_reg <= rec.x.travel;  dx_reg <= rec.x.delta;
            py_reg <= rec.y.dir_pos;  ty_reg <= rec.y.travel;  dy_reg <= rec.y.delta;
            pz_reg <= rec.z.dir_pos;  tz_reg <= rec.z.travel;  dz_reg <= rec.z.delta;
        end else if (adv) begin
            n_reg <= n_reg + CW'(1);
            if (sel_x) begin
                tx_reg <= sx[TD_W] ? '1 : sx[TD_W-1:0];
                x_reg  <= px_reg ? x_reg + IDX_W'(1) : x_reg - IDX_W'(1);
            end else if (sel_y) begin
                ty_reg <= sy[TD_W] ? '1 : sy[TD_W-1:0];
                y_reg  <= py_reg ? y_reg + IDX_W'(1) : y_reg - IDX_W'(1);
            end else begin
                tz_reg <= sz[TD_W] ? '1 : sz[TD_W-1:0];
                z_reg  <= pz_reg ? z_reg + IDX_W'(1) : z_reg - IDX_W'(1);
            end
        end
        if (adv) begin
            od_reg <= {z_reg[CELL_W-1:0], y_reg[CELL_W-1:0], x_reg[CELL_W-1:0]};
            ol_reg <= is_last;
            ou_reg <= outside_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;
    assign m_tuser  = ou_reg;

endmodule

// ===== rtl/voxel_ray_traversal_3d_top.sv =====
// ----------------------------------------------------------------------------
// voxel_ray_traversal_3d_top: 3D voxel ray traversal
// Takes rays as start and end points and streams the visited voxel indices.
// ----------------------------------------------------------------------------
// Each input transfer carries one ray; the block answers with the chain of
// voxels from the start cell to the end cell, one output transfer per cell,
// with tlast on the end cell and tuser set on every cell of the run when the
// end point lies outside the map box. The front end runs the setup for the
// three axes in parallel, each axis on its own bit-serial divider: two
// 25-step divisions for the start and end cells and two 40-step divisions
// for the travel increment and first boundary distance; an axis that does
// not move skips the last two. The front end takes a new ray only once the
// record of the last one has been handed into the queue. The walker loads
// a record and then emits one cell per cycle while the output is not
// stalled; a run has at most 46 cells with the default GRID_LEN. A two-entry
// queue separates the two, so the walker drains one ray while the front end
// sets up the next; the sustained rate is set by the setup unless the
// output side stalls. Configuration registers are written through the
// cfg port, which is always ready; write them only while no ray is in
// flight.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_3d_top #(
    parameter int GRID_LEN = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Ray input. tdata from bit 0: start_x, start_y, start_z, end_x, end_y,
    // end_z, 24 bits each.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [6*vrt_pkg::COORD_W-1:0]       s_tdata,
    // Cell output. tdata from bit 0: cell_x, cell_y, cell_z, 16 bits each.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [3*vrt_pkg::CELL_W-1:0]        m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser,   // outside_map
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vrt_pkg::COORD_W-1:0]         cfg_data
);
    import vrt_pkg::*;

    localparam logic [1:0] FE_IDLE = 2'd0;
    localparam logic [1:0] FE_RUN  = 2'd1;
    localparam logic [1:0] FE_PUSH = 2'd2;

    logic signed [COORD_W-1:0] org_x_reg, org_y_reg, org_z_reg;
    logic [CS_W-1:0]           cs_reg;
    logic signed [CELL_W-1:0]  lo_x_reg, lo_y_reg, lo_z_reg;

    logic [1:0] fe_reg, fe_next;
    logic       s_acc, push, full, empty, pop;
    logic       dn_x, dn_y, dn_z, out_x, out_y, out_z;
    ray_rec_t   rec_in, rec_out;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            cs_reg    <= CS_W'(256);
            lo_x_reg  <= -CELL_W'(8);
            lo_y_reg  <= -CELL_W'(8);
            lo_z_reg  <= -CELL_W'(8);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ORIGIN_X:    org_x_reg <= cfg_data;
                REG_ORIGIN_Y:    org_y_reg <= cfg_data;
                REG_ORIGIN_Z:    org_z_reg <= cfg_data;
                REG_CELL_SIZE:   cs_reg    <= cfg_data[CS_W-1:0];
                REG_INDEX_MIN_X: lo_x_reg  <= cfg_data[CELL_W-1:0];
                REG_INDEX_MIN_Y: lo_y_reg  <= cfg_data[CELL_W-1:0];
                REG_INDEX_MIN_Z: lo_z_reg  <= cfg_data[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: take a ray, run the three axis setups, queue the record.
    assign s_tready = (fe_reg == FE_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign push     = (fe_reg == FE_PUSH) && !full;

    always_comb begin
        fe_next = fe_reg;
        case (fe_reg)
            FE_IDLE: if (s_acc) fe_next = FE_RUN;
            FE_RUN:  if (dn_x && dn_y && dn_z) fe_next = FE_PUSH;
            FE_PUSH: if (!full) fe_next = FE_IDLE;
            default: fe_next = FE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) fe_reg <= FE_IDLE;
        else          fe_reg <= fe_next;
    end

    vrt_axis #(.GRID_LEN(GRID_LEN)) u_axis_x (
        .aclk(aclk), .aresetn(aresetn), .start(s_acc),
        .start_pos(s_tdata[0*COORD_W +: COORD_W]),
        .end_pos(s_tdata[3*COORD_W +: COORD_W]),
        .origin(org_x_reg), .cell_size(cs_reg), .index_min(lo_x_reg),
        .done(dn_x), .outside(out_x), .rec(rec_in.x)
    );

    vrt_axis #(.GRID_LEN(GRID_LEN)) u_axis_y (
        .aclk(aclk), .aresetn(aresetn), .start(s_acc),
        .start_pos(s_tdata[1*COORD_W +: COORD_W]),
        .end_pos(s_tdata[4*COORD_W +: COORD_W]),
        .origin(org_y_reg), .cell_size(cs_reg), .index_min(lo_y_reg),
        .done(dn_y), .outside(out_y), .rec(rec_in.y)
    );

    vrt_axis #(.GRID_LEN(GRID_LEN)) u_axis_z (
        .aclk(aclk), .aresetn(aresetn), .start(s_acc),
        .start_pos(s_tdata[2*COORD_W +: COORD_W]),
        .end_pos(s_tdata[5*COORD_W +: COORD_W]),
        .origin(org_z_reg), .cell_size(cs_reg), .index_min(lo_z_reg),
        .done(dn_z), .outside(out_z), .rec(rec_in.z)
    );

    assign rec_in.outside = out_x || out_y || out_z;

    vrt_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_data(rec_in), .full(full),
        .pop(pop), .empty(empty), .pop_data(rec_out)
    );

    // Back end: walk the cells of the queued ray.
    vrt_walk #(.GRID_LEN(GRID_LEN)) u_walk (
        .aclk(aclk), .aresetn(aresetn),
        .rec_empty(empty), .rec(rec_out), .rec_pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

endmodule
